/* src/set_pkg.sv */
// Shared types and constants for the thresholded Sobel edge block.
// Used by the channel interfaces and every set_* module; depends on nothing.
`timescale 1ns / 1ps

package set_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned ColW       = 10;
  localparam int unsigned RowW       = 16;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 16;
  localparam int unsigned CfgThrW    = 9;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned GradW      = 11;
  localparam int unsigned SqW        = 20;
  localparam int unsigned MagW       = 21;
  localparam int unsigned LimW       = 22;

  localparam logic [CfgWidthW-1:0]  WidthRst  = 11'd640;
  localparam logic [CfgHeightW-1:0] HeightRst = 16'd480;
  localparam logic [CfgThrW-1:0]    ThrRst    = 9'd50;
  localparam logic [LimW-1:0]       LimRst    = 22'd40000;

  localparam logic [PixW-1:0] EdgeOn  = 8'd255;
  localparam logic [PixW-1:0] EdgeOff = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } col_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] pix;
    logic            interior;
    logic            border;
    logic            flast;
  } meta_t;

endpackage

/* src/set_if.sv */
// Valid/ready channel interfaces: pixel input, result output, register writes.
// Depends on set_pkg for field widths.
`timescale 1ns / 1ps

interface set_pix_if;
  logic                       valid;
  logic                       ready;
  logic [set_pkg::PixW-1:0]   gray_value;
  logic                       frame_start;
  modport source (output valid, gray_value, frame_start, input ready);
  modport sink   (input valid, gray_value, frame_start, output ready);
endinterface

interface set_res_if;
  logic                       valid;
  logic                       ready;
  logic [set_pkg::RowW-1:0]   out_row;
  logic [set_pkg::ColW-1:0]   out_column;
  logic [set_pkg::PixW-1:0]   out_value;
  logic                       run_last;
  logic                       frame_last;
  modport source (output valid, out_row, out_column, out_value, run_last, frame_last,
                  input ready);
  modport sink   (input valid, out_row, out_column, out_value, run_last, frame_last,
                  output ready);
endinterface

interface set_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [set_pkg::CfgIdxW-1:0]  index;
  logic [set_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/set_line_store.sv */
// Two line memories (two rows up, one row up) with registered read and
// same-address forwarding from the write port. Depends on set_pkg.
`timescale 1ns / 1ps

module set_line_store #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic [set_pkg::PixW-1:0] wr_upper_i,
  input  logic [set_pkg::PixW-1:0] wr_middle_i,
  output logic [set_pkg::PixW-1:0] rd_upper_o,
  output logic [set_pkg::PixW-1:0] rd_middle_o
);

  logic [set_pkg::PixW-1:0] upper_mem  [Depth];
  logic [set_pkg::PixW-1:0] middle_mem [Depth];
  logic [set_pkg::PixW-1:0] rd_upper_q, rd_middle_q;
  logic [set_pkg::PixW-1:0] fwd_upper_q, fwd_middle_q;
  logic                     fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
    if (rd_en_i) begin
      rd_upper_q   <= upper_mem[rd_addr_i];
      rd_middle_q  <= middle_mem[rd_addr_i];
      fwd_upper_q  <= wr_upper_i;
      fwd_middle_q <= wr_middle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_upper_o  = fwd_q ? fwd_upper_q  : rd_upper_q;
  assign rd_middle_o = fwd_q ? fwd_middle_q : rd_middle_q;

endmodule

/* src/set_win_cell.sv */
// One column cell of the 3x3 window; takes its neighbor's column on enable.
// Depends on set_pkg for the column type.
`timescale 1ns / 1ps

module set_win_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  set_pkg::col_t col_i,
  output set_pkg::col_t col_o
);

  set_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

/* src/set_grad.sv */
// Sobel gradient stage then squaring stage, both advancing on enable.
// Depends on set_pkg for widths and the column type.
`timescale 1ns / 1ps

module set_grad (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  set_pkg::col_t           west_i,
  input  set_pkg::col_t           mid_i,
  input  set_pkg::col_t           east_i,
  output logic [set_pkg::SqW-1:0] sq_x_o,
  output logic [set_pkg::SqW-1:0] sq_y_o
);

  localparam int unsigned SumW = set_pkg::PixW + 2;

  logic        [SumW-1:0]                 px, mx, py, my;
  logic signed [set_pkg::GradW-1:0]       dx_d, dy_d, dx_q, dy_q;
  logic signed [2*set_pkg::GradW-1:0]     prod_x, prod_y;
  logic        [set_pkg::SqW-1:0]         sq_x_q, sq_y_q;

  assign px = {2'b00, east_i.top} + {1'b0, east_i.mid, 1'b0} + {2'b00, east_i.bot};
  assign mx = {2'b00, west_i.top} + {1'b0, west_i.mid, 1'b0} + {2'b00, west_i.bot};
  assign py = {2'b00, east_i.bot} + {1'b0, mid_i.bot, 1'b0}  + {2'b00, west_i.bot};
  assign my = {2'b00, east_i.top} + {1'b0, mid_i.top, 1'b0}  + {2'b00, west_i.top};

  assign dx_d = $signed({1'b0, px}) - $signed({1'b0, mx});
  assign dy_d = $signed({1'b0, py}) - $signed({1'b0, my});

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      sq_x_q <= prod_x[set_pkg::SqW-1:0];
      sq_y_q <= prod_y[set_pkg::SqW-1:0];
    end
  end

  assign sq_x_o = sq_x_q;
  assign sq_y_o = sq_y_q;

endmodule

/* src/sobel_edge_threshold.sv */
// Top level of the thresholded 3x3 Sobel edge block: position counters,
// registers, line store, window cell chain, gradient stages, result register.
// Depends on set_pkg, set_if, set_line_store, set_win_cell, set_grad.
//
//   channel | dir | payload                                        | accepted when
//   pix_i   | in  | gray_value, frame_start                        | valid && ready
//   res_o   | out | out_row, out_column, out_value, run_last, f.l. | valid && ready
//   cfg_i   | in  | index, data                                    | valid && ready
//
// One pixel per cycle unless stalled; a pixel is registered through s1, s2, s3 and the
// result register. A pixel yielding two results (row end or last row) holds the input
// until the first is taken; the single register emits one result per cycle when ready.
// Output stall freezes the whole pipe; input ready follows the result register.
// Reset clears counters and window; line stores hold no valid data until written.
`timescale 1ns / 1ps

module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  set_pix_if.sink       pix_i,
  set_res_if.source     res_o,
  set_cfg_if.sink       cfg_i
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned MWW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WEW  = (set_pkg::CfgWidthW > MWW) ? set_pkg::CfgWidthW : MWW;
  localparam int unsigned IW0  = (set_pkg::ColW > AW) ? set_pkg::ColW : AW;
  localparam int unsigned IW   = IW0 + 1;
  localparam int unsigned RW   = set_pkg::RowW;
  localparam int unsigned CW   = set_pkg::ColW;

  // Registers
  logic [set_pkg::CfgWidthW-1:0]  width_q;
  logic [set_pkg::CfgHeightW-1:0] height_q;
  logic [set_pkg::CfgThrW-1:0]    thr_q;
  logic [set_pkg::LimW-1:0]       lim_q;
  logic [2*set_pkg::CfgThrW-1:0]  thr_sq;

  // Position
  logic [CW-1:0]  col_q, col_d, c;
  logic [RW-1:0]  row_q, row_d, r;
  logic [WEW-1:0] w_raw, w, c_ext, c1;
  logic [RW-1:0]  h;
  logic [RW:0]    r1;
  logic [IW-1:0]  c_idx;
  logic [AW-1:0]  idx;
  logic           end_col, end_row, interior, border;

  // Pipeline
  logic                adv, accept;
  logic                s1_valid_q, s2_valid_q, s3_valid_q;
  set_pkg::meta_t      s1_meta_q, s2_meta_q, s3_meta_q, in_meta;
  logic [AW-1:0]       s1_idx_q;
  logic                p_valid_q, p_has_int_q, p_has_brd_q, p_edge_q;
  set_pkg::meta_t      p_meta_q;
  logic                last_piece;

  logic [set_pkg::PixW-1:0] rd_upper, rd_middle;
  set_pkg::col_t            cur_col, cell_b, cell_a;
  logic [set_pkg::SqW-1:0]  sq_x, sq_y;
  logic [set_pkg::MagW-1:0] mag;
  logic                     shift_en;

  assign thr_sq = thr_q * thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= set_pkg::WidthRst;
      height_q <= set_pkg::HeightRst;
      thr_q    <= set_pkg::ThrRst;
      lim_q    <= set_pkg::LimRst;
    end else begin
      lim_q <= {thr_sq, 4'b0000};
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          set_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_i.data[set_pkg::CfgWidthW-1:0];
          set_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_i.data[set_pkg::CfgHeightW-1:0];
          set_pkg::REG_EDGE_THRESHOLD: thr_q    <= cfg_i.data[set_pkg::CfgThrW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Position of the incoming pixel and its classification
  always_comb begin
    c     = pix_i.frame_start ? '0 : col_q;
    r     = pix_i.frame_start ? '0 : row_q;
    w_raw = WEW'(width_q);
    if (w_raw == '0) begin
      w = WEW'(1);
    end else if (w_raw > WEW'(MAX_WIDTH)) begin
      w = WEW'(MAX_WIDTH);
    end else begin
      w = w_raw;
    end
    h        = (height_q == '0) ? RW'(1) : height_q;
    c_ext    = WEW'(c);
    c1       = c_ext + WEW'(1);
    r1       = {1'b0, r} + (RW+1)'(1);
    end_col  = c1 >= w;
    end_row  = r1 >= {1'b0, h};
    interior = (c >= CW'(2)) && (c_ext < w) && (r >= RW'(2)) && (r < h);
    border   = (r == '0) || end_row || (c == '0) || end_col;
    c_idx    = IW'(c);
    idx      = (c_idx < IW'(MAX_WIDTH)) ? c_idx[AW-1:0] : AW'(MAX_WIDTH - 1);
    if (end_col) begin
      col_d = '0;
      row_d = end_row ? '0 : r1[RW-1:0];
    end else begin
      col_d = c + CW'(1);
      row_d = r;
    end
    in_meta.row      = r;
    in_meta.col      = c;
    in_meta.pix      = pix_i.gray_value;
    in_meta.interior = interior;
    in_meta.border   = border;
    in_meta.flast    = end_col && end_row;
  end

  assign last_piece  = !p_has_int_q || !p_has_brd_q;
  assign adv         = !p_valid_q || (res_o.ready && last_piece);
  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;
  assign shift_en    = adv && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  set_line_store #(
    .Depth (MAX_WIDTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (idx),
    .wr_en_i     (shift_en),
    .wr_addr_i   (s1_idx_q),
    .wr_upper_i  (rd_middle),
    .wr_middle_i (s1_meta_q.pix),
    .rd_upper_o  (rd_upper),
    .rd_middle_o (rd_middle)
  );

  assign cur_col.top = rd_upper;
  assign cur_col.mid = rd_middle;
  assign cur_col.bot = s1_meta_q.pix;

  set_win_cell u_cell_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_en),
    .col_i  (cur_col),
    .col_o  (cell_b)
  );

  set_win_cell u_cell_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_en),
    .col_i  (cell_b),
    .col_o  (cell_a)
  );

  set_grad u_grad (
    .clk_i  (clk_i),
    .en_i   (adv),
    .west_i (cell_a),
    .mid_i  (cell_b),
    .east_i (cur_col),
    .sq_x_o (sq_x),
    .sq_y_o (sq_y)
  );

  assign mag = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      p_valid_q   <= 1'b0;
      p_has_int_q <= 1'b0;
      p_has_brd_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      p_valid_q   <= s3_valid_q && (s3_meta_q.interior || s3_meta_q.border);
      p_has_int_q <= s3_valid_q && s3_meta_q.interior;
      p_has_brd_q <= s3_valid_q && s3_meta_q.border;
    end else if (res_o.valid && res_o.ready) begin
      p_has_int_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= in_meta;
      s1_idx_q  <= idx;
    end
    if (adv) begin
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
      p_meta_q  <= s3_meta_q;
      p_edge_q  <= {1'b0, mag} > lim_q;
    end
  end

  always_comb begin
    res_o.valid = p_valid_q;
    if (p_has_int_q) begin
      res_o.out_row    = p_meta_q.row - RW'(1);
      res_o.out_column = p_meta_q.col - CW'(1);
      res_o.out_value  = p_edge_q ? set_pkg::EdgeOn : set_pkg::EdgeOff;
      res_o.run_last   = !p_has_brd_q;
      res_o.frame_last = 1'b0;
    end else begin
      res_o.out_row    = p_meta_q.row;
      res_o.out_column = p_meta_q.col;
      res_o.out_value  = p_meta_q.pix;
      res_o.run_last   = 1'b1;
      res_o.frame_last = p_meta_q.flast;
    end
  end

endmodule
